[design/scr_pkg.sv]
package scr_pkg;

   localparam int DEF_MAX_SEQ      = 1024;
   localparam int DEF_MAX_SEGMENTS = 1024;
   localparam int DEF_POS_BITS     = 40;

   localparam int SEQ_W  = 10;
   localparam int POS_W  = 40;
   localparam int QUAL_W = 8;
   localparam int PART_W = 11;

   typedef enum logic {
      MODE_LOAD = 1'b0,
      MODE_LINK = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_KEPT     = 2'd0,
      STATUS_DROPPED  = 2'd1,
      STATUS_STORED   = 2'd2,
      STATUS_REJECTED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_INDEX,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      mode_type           mode;
      logic [SEQ_W-1:0]   seg_seq;
      logic [POS_W-1:0]   seg_begin;
      logic [POS_W-1:0]   seg_end;
      logic [SEQ_W-1:0]   first_seq;
      logic [POS_W-1:0]   first_pos;
      logic [QUAL_W-1:0]  first_quality;
      logic [SEQ_W-1:0]   second_seq;
      logic [POS_W-1:0]   second_pos;
      logic [QUAL_W-1:0]  second_quality;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [PART_W-1:0]  first_part;
      logic [POS_W-1:0]   first_offset;
      logic [QUAL_W-1:0]  first_quality_out;
      logic [PART_W-1:0]  second_part;
      logic [POS_W-1:0]   second_offset;
      logic [QUAL_W-1:0]  second_quality_out;
   } rsp_type;

endpackage

[design/segment_coordinate_remapper.sv]
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_stall  | scr_pkg::req_type (load segment or link pair)
// rsp     | out | rsp_valid/rsp_stall  | scr_pkg::rsp_type (one result per request)
//
// Load: accept, index read-modify-write, result.
// Link: accept, one index read per end, a walk over the parts of each split end, then
// the result; a walk stops at the first part that holds the end, or drops the link after
// the sequence's last part. The segment store port does one segment a cycle.
// After reset the sequence index is cleared, one entry a cycle (MAX_SEQ entries,
// at most 1024); req_stall stays high meanwhile.
// A finished beat waits in the result register; the next request is taken meanwhile.
module segment_coordinate_remapper #(
   parameter int MAX_SEQ      = scr_pkg::DEF_MAX_SEQ,
   parameter int MAX_SEGMENTS = scr_pkg::DEF_MAX_SEGMENTS,
   parameter int POS_BITS     = scr_pkg::DEF_POS_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  scr_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output scr_pkg::rsp_type rsp_payload
);

   localparam int SEQ_DEPTH = (MAX_SEQ < (1 << scr_pkg::SEQ_W)) ? MAX_SEQ
                                                               : (1 << scr_pkg::SEQ_W);
   localparam int IDX_AW = $clog2(SEQ_DEPTH);
   localparam int SEG_AW = $clog2(MAX_SEGMENTS);
   localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int SW     = (POS_BITS < scr_pkg::POS_W) ? POS_BITS : scr_pkg::POS_W;

   localparam logic [16:0]       MAX_SEQ_V = 17'(MAX_SEQ);
   localparam logic [CNT_W-1:0]  MAX_SEG_V = CNT_W'(MAX_SEGMENTS);
   localparam logic [IDX_AW-1:0] CLR_LAST  = IDX_AW'(SEQ_DEPTH - 1);

   typedef struct packed {
      logic [SEG_AW-1:0] start;
      logic [CNT_W-1:0]  count;
   } idx_entry_type;

   typedef struct packed {
      logic [SW-1:0] lo;
      logic [SW-1:0] hi;
   } seg_entry_type;

   function automatic logic seq_in_range(input logic [scr_pkg::SEQ_W-1:0] s);
      return {7'd0, s} < MAX_SEQ_V;
   endfunction

   function automatic logic [scr_pkg::POS_W-1:0] ext_pos(input logic [SW-1:0] v);
      logic [SW+scr_pkg::POS_W-1:0] w;
      w = {{scr_pkg::POS_W{1'b0}}, v};
      return w[scr_pkg::POS_W-1:0];
   endfunction

   function automatic logic [scr_pkg::PART_W-1:0] to_part(input logic [CNT_W-1:0] v);
      logic [CNT_W+scr_pkg::PART_W-1:0] w;
      w = {{scr_pkg::PART_W{1'b0}}, v};
      return w[scr_pkg::PART_W-1:0];
   endfunction

   scr_pkg::state_type state_ff, state_in;
   scr_pkg::req_type   req_ff, req_in;
   logic               end_sel_ff, end_sel_in;
   logic [IDX_AW-1:0]  clr_ptr_ff, clr_ptr_in;
   logic [CNT_W-1:0]   seg_count_ff, seg_count_in;
   logic [scr_pkg::SEQ_W-1:0] last_seq_ff, last_seq_in;
   logic [SEG_AW-1:0]  seg_addr_ff, seg_addr_in;
   logic [CNT_W-1:0]   walk_cnt_ff, walk_cnt_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   scr_pkg::status_type status_ff, status_in;
   logic [scr_pkg::PART_W-1:0] part0_ff, part0_in, part1_ff, part1_in;
   logic [scr_pkg::POS_W-1:0]  off0_ff, off0_in, off1_ff, off1_in;
   logic               rsp_valid_ff, rsp_valid_in;
   scr_pkg::rsp_type   rsp_ff, rsp_in;

   idx_entry_type      idx_mem [SEQ_DEPTH];
   idx_entry_type      idx_rd_q, idx_wr_data;
   logic [IDX_AW-1:0]  idx_rd_addr, idx_wr_addr;
   logic               idx_we;
   logic [scr_pkg::SEQ_W-1:0] idx_rd_seq;

   seg_entry_type      seg_mem [MAX_SEGMENTS];
   seg_entry_type      seg_rd_q, seg_wr_data;
   logic [SEG_AW-1:0]  seg_rd_addr;
   logic               seg_we;

   logic [scr_pkg::SEQ_W-1:0] cur_seq;
   logic [scr_pkg::POS_W-1:0] cur_pos_full;
   logic [SW-1:0]      cur_pos;
   logic [SW-1:0]      diff;
   logic [CNT_W-1:0]   k_next;
   logic               hit;
   logic               slot_free;
   logic               store_ok;
   logic               end_done;
   logic [scr_pkg::PART_W-1:0] end_part;
   logic [scr_pkg::POS_W-1:0]  end_off;

   assign cur_seq      = end_sel_ff ? req_ff.second_seq : req_ff.first_seq;
   assign cur_pos_full = end_sel_ff ? req_ff.second_pos : req_ff.first_pos;
   assign cur_pos      = cur_pos_full[SW-1:0];
   assign hit          = (seg_rd_q.lo <= cur_pos) && (cur_pos < seg_rd_q.hi);
   assign diff         = cur_pos - seg_rd_q.lo;
   assign k_next       = k_ff + CNT_W'(1);
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign store_ok     = (seg_count_ff < MAX_SEG_V) && seq_in_range(req_ff.seg_seq) &&
                         (req_ff.seg_seq >= last_seq_ff);

   // index read: new request in idle, otherwise the second end of the held link
   assign idx_rd_seq  = (state_ff != scr_pkg::ST_IDLE) ? req_ff.second_seq :
                        (req_payload.mode == scr_pkg::MODE_LOAD) ? req_payload.seg_seq :
                        req_payload.first_seq;
   assign idx_rd_addr = idx_rd_seq[IDX_AW-1:0];

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      end_sel_in   = end_sel_ff;
      clr_ptr_in   = clr_ptr_ff;
      seg_count_in = seg_count_ff;
      last_seq_in  = last_seq_ff;
      seg_addr_in  = seg_addr_ff;
      walk_cnt_in  = walk_cnt_ff;
      k_in         = k_ff;
      status_in    = status_ff;
      part0_in     = part0_ff;
      part1_in     = part1_ff;
      off0_in      = off0_ff;
      off1_in      = off1_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      idx_we       = 1'b0;
      idx_wr_addr  = req_ff.seg_seq[IDX_AW-1:0];
      idx_wr_data  = '0;
      seg_we       = 1'b0;
      seg_wr_data.lo = req_ff.seg_begin[SW-1:0];
      seg_wr_data.hi = req_ff.seg_end[SW-1:0];
      seg_rd_addr  = seg_addr_ff;
      end_done     = 1'b0;
      end_part     = '0;
      end_off      = ext_pos(cur_pos);

      unique case (state_ff)
         scr_pkg::ST_CLEAR: begin
            idx_we      = 1'b1;
            idx_wr_addr = clr_ptr_ff;
            clr_ptr_in  = clr_ptr_ff + IDX_AW'(1);
            if (clr_ptr_ff == CLR_LAST) begin
               state_in = scr_pkg::ST_IDLE;
            end
         end
         scr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in     = req_payload;
               end_sel_in = 1'b0;
               state_in   = (req_payload.mode == scr_pkg::MODE_LOAD) ? scr_pkg::ST_LOAD
                                                                     : scr_pkg::ST_INDEX;
            end
         end
         scr_pkg::ST_LOAD: begin
            if (store_ok) begin
               seg_we            = 1'b1;
               idx_we            = 1'b1;
               idx_wr_data.start = (idx_rd_q.count == '0) ? seg_count_ff[SEG_AW-1:0]
                                                          : idx_rd_q.start;
               idx_wr_data.count = idx_rd_q.count + CNT_W'(1);
               seg_count_in      = seg_count_ff + CNT_W'(1);
               last_seq_in       = req_ff.seg_seq;
               status_in         = scr_pkg::STATUS_STORED;
            end else begin
               status_in = scr_pkg::STATUS_REJECTED;
            end
            state_in = scr_pkg::ST_FINISH;
         end
         scr_pkg::ST_INDEX: begin
            if (!seq_in_range(cur_seq) || idx_rd_q.count == '0) begin
               end_done = 1'b1;
            end else begin
               seg_rd_addr = idx_rd_q.start;
               seg_addr_in = idx_rd_q.start;
               walk_cnt_in = idx_rd_q.count;
               k_in        = '0;
               state_in    = scr_pkg::ST_WALK;
            end
         end
         scr_pkg::ST_WALK: begin
            if (hit) begin
               end_done = 1'b1;
               end_part = to_part(k_next);
               end_off  = ext_pos(diff);
            end else if (k_next == walk_cnt_ff) begin
               status_in = scr_pkg::STATUS_DROPPED;
               state_in  = scr_pkg::ST_FINISH;
            end else begin
               k_in        = k_next;
               seg_addr_in = seg_addr_ff + SEG_AW'(1);
               seg_rd_addr = seg_addr_ff + SEG_AW'(1);
            end
         end
         scr_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_in             = '0;
               rsp_in.status      = status_ff;
               if (req_ff.mode == scr_pkg::MODE_LINK) begin
                  rsp_in.first_quality_out  = req_ff.first_quality;
                  rsp_in.second_quality_out = req_ff.second_quality;
               end
               if (status_ff == scr_pkg::STATUS_KEPT) begin
                  rsp_in.first_part    = part0_ff;
                  rsp_in.first_offset  = off0_ff;
                  rsp_in.second_part   = part1_ff;
                  rsp_in.second_offset = off1_ff;
               end
               rsp_valid_in = 1'b1;
               state_in     = scr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scr_pkg::ST_IDLE;
         end
      endcase

      // an end is settled: record it, then move to the second end or finish
      if (end_done) begin
         if (end_sel_ff) begin
            part1_in  = end_part;
            off1_in   = end_off;
            status_in = scr_pkg::STATUS_KEPT;
            state_in  = scr_pkg::ST_FINISH;
         end else begin
            part0_in   = end_part;
            off0_in    = end_off;
            end_sel_in = 1'b1;
            state_in   = scr_pkg::ST_INDEX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scr_pkg::ST_CLEAR;
         end_sel_ff   <= 1'b0;
         clr_ptr_ff   <= '0;
         seg_count_ff <= '0;
         last_seq_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         end_sel_ff   <= end_sel_in;
         clr_ptr_ff   <= clr_ptr_in;
         seg_count_ff <= seg_count_in;
         last_seq_ff  <= last_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      seg_addr_ff <= seg_addr_in;
      walk_cnt_ff <= walk_cnt_in;
      k_ff        <= k_in;
      status_ff   <= status_in;
      part0_ff    <= part0_in;
      part1_ff    <= part1_in;
      off0_ff     <= off0_in;
      off1_ff     <= off1_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (idx_we) begin
         idx_mem[idx_wr_addr] <= idx_wr_data;
      end
      idx_rd_q <= idx_mem[idx_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (seg_we) begin
         seg_mem[seg_count_ff[SEG_AW-1:0]] <= seg_wr_data;
      end
      seg_rd_q <= seg_mem[seg_rd_addr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a previous one is still in work");

   a_walk_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scr_pkg::ST_WALK) |-> (CNT_W'(seg_addr_ff) < seg_count_ff))
      else $error("segment walk beyond the stored segments");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scr_pkg::ST_WALK) |-> (k_ff < walk_cnt_ff))
      else $error("segment walk past the sequence's run");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      seg_count_ff <= MAX_SEG_V)
      else $error("segment count exceeds the table size");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scr_pkg::ST_FINISH && rsp_valid_ff && rsp_stall)
      |=> (state_ff == scr_pkg::ST_FINISH && rsp_valid_ff))
      else $error("result overwrote a stalled beat");

endmodule

[sim/segment_coordinate_remapper_checker.sv]
module segment_coordinate_remapper_checker
   import scr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      mismatches,
   output int      pending
);

   localparam int SEQ_SLOTS = DEF_MAX_SEQ;
   localparam int SEG_SLOTS = DEF_MAX_SEGMENTS;

   // shadow of the segment table and the per-sequence run index
   logic [POS_W-1:0] part_lo [SEG_SLOTS];
   logic [POS_W-1:0] part_hi [SEG_SLOTS];
   int unsigned      run_first [SEQ_SLOTS];
   int unsigned      run_len [SEQ_SLOTS];
   int unsigned      slots_used;
   logic [SEQ_W-1:0] newest_seq;

   rsp_type expected_remaps [$];

   // Unsplit sequences keep their position; split ones take the first part that holds it.
   function automatic logic locate_end(input logic [SEQ_W-1:0] seq,
                                       input logic [POS_W-1:0] pos,
                                       output logic [PART_W-1:0] part,
                                       output logic [POS_W-1:0] offset);
      int unsigned k;
      int unsigned slot;
      part = '0;
      offset = pos;
      if (int'(seq) >= SEQ_SLOTS || run_len[seq] == 0)
         return 1'b1;
      for (k = 0; k < run_len[seq]; k++) begin
         slot = run_first[seq] + k;
         if (slot >= SEG_SLOTS)
            break;
         if (part_lo[slot] <= pos && pos < part_hi[slot]) begin
            part = PART_W'(k + 1);
            offset = pos - part_lo[slot];
            return 1'b1;
         end
      end
      offset = '0;
      return 1'b0;
   endfunction

   function automatic rsp_type remap_beat(input req_type beat);
      rsp_type           res;
      logic [PART_W-1:0] part_a, part_b;
      logic [POS_W-1:0]  off_a, off_b;
      logic              held;
      res = '0;
      if (beat.mode == MODE_LOAD) begin
         if (slots_used >= SEG_SLOTS || int'(beat.seg_seq) >= SEQ_SLOTS ||
             beat.seg_seq < newest_seq) begin
            res.status = STATUS_REJECTED;
         end else begin
            part_lo[slots_used] = beat.seg_begin;
            part_hi[slots_used] = beat.seg_end;
            if (run_len[beat.seg_seq] == 0)
               run_first[beat.seg_seq] = slots_used;
            run_len[beat.seg_seq]++;
            slots_used++;
            newest_seq = beat.seg_seq;
            res.status = STATUS_STORED;
         end
      end else begin
         res.first_quality_out = beat.first_quality;
         res.second_quality_out = beat.second_quality;
         held = locate_end(beat.first_seq, beat.first_pos, part_a, off_a) &&
                locate_end(beat.second_seq, beat.second_pos, part_b, off_b);
         if (held) begin
            res.status = STATUS_KEPT;
            res.first_part = part_a;
            res.first_offset = off_a;
            res.second_part = part_b;
            res.second_offset = off_b;
         end else begin
            res.status = STATUS_DROPPED;
         end
      end
      return res;
   endfunction

   task automatic report_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      int      i;
      if (reset) begin
         for (i = 0; i < SEQ_SLOTS; i++)
            run_len[i] = 0;
         slots_used = 0;
         newest_seq = '0;
         expected_remaps.delete();
         mismatches = 0;
         pending = 0;
      end else begin
         // compare before predicting so a stray beat cannot pair with a fresh request
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (expected_remaps.size() == 0) begin
               report_field("unexpected beat, status", '0, 64'(got.status));
            end else begin
               want = expected_remaps.pop_front();
               if (got.status != want.status)
                  report_field("status", 64'(want.status), 64'(got.status));
               if (got.first_part != want.first_part)
                  report_field("first_part", 64'(want.first_part), 64'(got.first_part));
               if (got.first_offset != want.first_offset)
                  report_field("first_offset", 64'(want.first_offset),
                               64'(got.first_offset));
               if (got.first_quality_out != want.first_quality_out)
                  report_field("first_quality_out", 64'(want.first_quality_out),
                               64'(got.first_quality_out));
               if (got.second_part != want.second_part)
                  report_field("second_part", 64'(want.second_part), 64'(got.second_part));
               if (got.second_offset != want.second_offset)
                  report_field("second_offset", 64'(want.second_offset),
                               64'(got.second_offset));
               if (got.second_quality_out != want.second_quality_out)
                  report_field("second_quality_out", 64'(want.second_quality_out),
                               64'(got.second_quality_out));
            end
         end
         if (req_valid && !req_stall)
            expected_remaps.push_back(remap_beat(req_payload));
         pending = expected_remaps.size();
      end
   end

endmodule

[sim/segment_coordinate_remapper_test.sv]
module segment_coordinate_remapper_test;
   import scr_pkg::*;

   localparam int SEQ_SLOTS  = DEF_MAX_SEQ;
   localparam int SEG_SLOTS  = DEF_MAX_SEGMENTS;
   localparam int ITEMS      = 1450;
   localparam int TAIL_ITEMS = 150;
   localparam int LINGER     = 64;
   localparam logic [POS_W-1:0] POS_TOP = '1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   int mismatches;
   int pending;
   int sent_count = 0;
   logic calm;

   // what the stimulus has laid into the table, used to aim link ends, order loads and top the table up
   logic [POS_W-1:0] laid_lo [SEG_SLOTS];
   logic [POS_W-1:0] laid_hi [SEG_SLOTS];
   int               laid_first [SEQ_SLOTS];
   int               laid_len [SEQ_SLOTS] = '{default: 0};
   int               laid_total = 0;
   logic [SEQ_W-1:0] laid_newest = '0;
   int               split_ids [$];

   int  hold_left = 0;
   logic hold_done = 1'b0;

   segment_coordinate_remapper uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   segment_coordinate_remapper_checker remap_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // no idling on either side while this window is open
   assign calm = sent_count >= 500 && sent_count < 700;

   // receiver: random stalls, plus one long hold-off so the block backs up
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && sent_count >= 300) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && $urandom_range(99) < 12;
      end
   end

   function automatic logic [POS_W-1:0] rand_pos();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      return wide[POS_W-1:0] >> $urandom_range(POS_W - 1);
   endfunction

   function automatic req_type random_beat();
      logic [255:0] noise;
      int           i;
      for (i = 0; i < 8; i++)
         noise[i*32 +: 32] = $urandom;
      return noise[$bits(req_type)-1:0];
   endfunction

   task automatic send_beat(input req_type beat);
      while (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sent_count++;
   endtask

   task automatic send_load(input logic [SEQ_W-1:0] seq, input logic [POS_W-1:0] lo,
                            input logic [POS_W-1:0] hi);
      req_type beat;
      beat = random_beat();
      beat.mode = MODE_LOAD;
      beat.seg_seq = seq;
      beat.seg_begin = lo;
      beat.seg_end = hi;
      if (laid_total < SEG_SLOTS && seq >= laid_newest) begin
         laid_lo[laid_total] = lo;
         laid_hi[laid_total] = hi;
         if (laid_len[seq] == 0) begin
            laid_first[seq] = laid_total;
            split_ids.push_back(seq);
         end
         laid_len[seq]++;
         laid_total++;
         laid_newest = seq;
      end
      send_beat(beat);
   endtask

   task automatic send_link(input logic [SEQ_W-1:0] seq_a, input logic [POS_W-1:0] pos_a,
                            input logic [QUAL_W-1:0] qual_a,
                            input logic [SEQ_W-1:0] seq_b, input logic [POS_W-1:0] pos_b,
                            input logic [QUAL_W-1:0] qual_b);
      req_type beat;
      beat = random_beat();
      beat.mode = MODE_LINK;
      beat.first_seq = seq_a;
      beat.first_pos = pos_a;
      beat.first_quality = qual_a;
      beat.second_seq = seq_b;
      beat.second_pos = pos_b;
      beat.second_quality = qual_b;
      send_beat(beat);
   endtask

   task automatic make_segment(output logic [POS_W-1:0] lo, output logic [POS_W-1:0] hi);
      lo = rand_pos();
      case ($urandom_range(15))
         0: hi = lo;
         1: hi = lo - 1 - $urandom_range(1000);
         default: hi = lo + (rand_pos() >> $urandom_range(POS_W - 1));
      endcase
   endtask

   // mostly aimed at a laid part: its edges, just past it, or somewhere inside
   task automatic pick_end(output logic [SEQ_W-1:0] seq, output logic [POS_W-1:0] pos);
      int               slot;
      logic [POS_W-1:0] lo, hi;
      seq = SEQ_W'($urandom_range(SEQ_SLOTS - 1));
      pos = rand_pos();
      if ($urandom_range(99) < 60 && split_ids.size() != 0) begin
         seq = SEQ_W'(split_ids[$urandom_range(split_ids.size() - 1)]);
         slot = laid_first[seq] + $urandom_range(laid_len[seq] - 1);
         lo = laid_lo[slot];
         hi = laid_hi[slot];
         case ($urandom_range(5))
            0: pos = lo;
            1: pos = hi - 1;
            2: pos = hi;
            default: if (hi > lo) pos = lo + rand_pos() % (hi - lo);
         endcase
      end
   endtask

   task automatic random_link();
      logic [SEQ_W-1:0] seq_a, seq_b;
      logic [POS_W-1:0] pos_a, pos_b;
      pick_end(seq_a, pos_a);
      pick_end(seq_b, pos_b);
      send_link(seq_a, pos_a, QUAL_W'($urandom_range(255)), seq_b, pos_b,
                QUAL_W'($urandom_range(255)));
   endtask

   initial begin
      int               next_seq;
      int               burst;
      logic [POS_W-1:0] lo, hi;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty table: both ends unsplit, extreme ids, positions and qualities
      send_link(0, 0, 0, SEQ_W'(SEQ_SLOTS - 1), POS_TOP, 255);
      // sequence 0: normal, empty, inverted and top-reaching parts
      send_load(0, 0, 100);
      send_load(0, 100, 100);
      send_load(0, 500, 200);
      send_load(0, 200, POS_TOP);
      send_link(0, 0, 255, 0, 99, 0);
      send_link(0, 100, 17, 7, 12345, 34);
      send_link(0, POS_TOP - 1, 1, 0, POS_TOP, 2);
      send_link(5, POS_TOP, 128, 0, 300, 127);
      // later sequence, then an out-of-order load, then same sequence again
      send_load(3, POS_TOP - 10, POS_TOP);
      send_load(2, 1, 2);
      send_load(3, 0, 0);
      send_link(3, POS_TOP - 1, 3, 3, 5, 4);
      send_link(3, 0, 5, 9, 0, 6);
      send_link(3, POS_TOP - 10, 200, 0, 250, 100);

      // runs of loads per sequence in rising order, each followed by links
      while (sent_count < ITEMS - TAIL_ITEMS) begin
         next_seq = laid_newest + $urandom_range(5);
         if (next_seq > SEQ_SLOTS - 2)
            next_seq = SEQ_SLOTS - 2;
         burst = ($urandom_range(19) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 10);
         repeat (burst) begin
            make_segment(lo, hi);
            send_load(SEQ_W'(next_seq), lo, hi);
         end
         repeat ($urandom_range(1, 4))
            random_link();
         if ($urandom_range(3) == 0) begin
            make_segment(lo, hi);
            if (laid_newest != 0 && $urandom_range(1) == 1)
               send_load(SEQ_W'($urandom_range(laid_newest - 1)), lo, hi);
            else
               send_link(SEQ_W'($urandom), rand_pos(), QUAL_W'($urandom),
                         SEQ_W'($urandom), rand_pos(), QUAL_W'($urandom));
         end
      end

      // top the table up so that full-table rejects are reached
      while (laid_total < SEG_SLOTS) begin
         make_segment(lo, hi);
         send_load(SEQ_W'(SEQ_SLOTS - 1), lo, hi);
      end
      repeat (TAIL_ITEMS) begin
         if ($urandom_range(3) == 0) begin
            make_segment(lo, hi);
            send_load(SEQ_W'($urandom_range(SEQ_SLOTS - 1)), lo, hi);
         end else begin
            random_link();
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (LINGER) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #32000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[segment_coordinate_remapper.f]
design/scr_pkg.sv
design/segment_coordinate_remapper.sv
sim/segment_coordinate_remapper_checker.sv
sim/segment_coordinate_remapper_test.sv
